// ===== sv/strided_tensor_offset_generator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the strided tensor offset generator.
// Every macro samples on the rising edge of aclk and is off during reset.
// ----------------------------------------------------------------------------
`ifndef STRIDED_TENSOR_OFFSET_GENERATOR_TOP_MACROS_SVH
`define STRIDED_TENSOR_OFFSET_GENERATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STOG_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define STOG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== sv/stog_pkg.sv =====
// ----------------------------------------------------------------------------
// stog_pkg
// Shared widths, register indexes and types of the strided offset generator.
// ----------------------------------------------------------------------------
package stog_pkg;

    // Dimension storage and datapath widths.
    localparam int MAX_DIMS     = 4;
    localparam int NUM_DESC     = 4;
    localparam int DIM_SLOTS    = (MAX_DIMS < NUM_DESC) ? MAX_DIMS : NUM_DESC;
    localparam int DIM_IDX_BITS = (DIM_SLOTS > 1) ? $clog2(DIM_SLOTS) : 1;
    localparam int OFFSET_BITS  = 32;
    localparam int SHAPE_BITS   = 16;
    localparam int COUNT_BITS   = 32;
    localparam int DIMS_BITS    = 3;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Register indexes; descriptors occupy indexes 0 to NUM_DESC-1.
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIMS_IN_USE   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ELEMENT_COUNT = 3'd5;

    // Reset value of the dimension count register.
    localparam logic [DIMS_BITS-1:0] DIMS_RESET = 3'd1;

    typedef logic [SHAPE_BITS-1:0]  dim_val_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    // Packed dimension descriptor, matching the register layout.
    typedef struct packed {
        dim_val_t shape;
        dim_val_t lhs_stride;
        dim_val_t rhs_stride;
        dim_val_t out_stride;
    } dim_desc_t;

    // One offset for each of the three tensors.
    typedef struct packed {
        offset_t lhs;
        offset_t rhs;
        offset_t out;
    } offset_set_t;

endpackage

// ===== sv/strided_tensor_offset_generator_top.sv =====
// ----------------------------------------------------------------------------
// strided_tensor_offset_generator_top: odometer offset generator, one element per transaction.
// Each result is registered in the cycle after its request is accepted.
// Throughput: one transaction per cycle unless m_ready stalls; full carry is combinational.
// Reset: synchronous active-low aresetn clears the walk, empties the output, dims_in_use = 1.
// ----------------------------------------------------------------------------
`include "strided_tensor_offset_generator_top_macros.svh"

module strided_tensor_offset_generator_top
    import stog_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    // Configuration write port.
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,

    // Request channel.
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_restart,

    // Result channel.
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [OFFSET_BITS-1:0]    m_lhs_addr,
    output logic [OFFSET_BITS-1:0]    m_rhs_addr,
    output logic [OFFSET_BITS-1:0]    m_out_addr,
    output logic [COUNT_BITS-1:0]     m_element_index,
    output logic                      m_last,
    output logic                      m_overrun
);

    // Configuration registers; strides kept widened and wrap deltas precomputed.
    dim_val_t       shape_reg [DIM_SLOTS];
    offset_set_t    stride_reg [DIM_SLOTS];
    offset_set_t    wrap_reg [DIM_SLOTS];
    logic [DIMS_BITS-1:0] dims_in_use_reg;
    count_t         element_count_reg;

    // Walk state.
    dim_val_t       dim_counter_reg [DIM_SLOTS];
    offset_set_t    position_reg;
    count_t         elements_done_reg;

    // Output register.
    logic           m_valid_reg;
    offset_set_t    m_offsets_reg;
    count_t         m_element_index_reg;
    logic           m_last_reg;
    logic           m_overrun_reg;

    // Step logic.
    dim_desc_t      cfg_desc;
    logic [2*SHAPE_BITS-1:0] lhs_prod;
    logic [2*SHAPE_BITS-1:0] rhs_prod;
    logic [2*SHAPE_BITS-1:0] out_prod;
    logic           accept;
    logic [DIMS_BITS-1:0] used_dims;
    logic [DIMS_BITS-1:0] inner_dim;
    dim_val_t       counter_cur [DIM_SLOTS];
    dim_val_t       counter_inc [DIM_SLOTS];
    dim_val_t       dim_counter_next [DIM_SLOTS];
    offset_set_t    dim_step [DIM_SLOTS];
    offset_set_t    position_cur;
    offset_set_t    position_next;
    count_t         done_cur;
    count_t         elements_done_next;
    logic           step_overrun;
    logic           carry;
    logic           touched;
    logic           wraps;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // Wrap delta of a descriptor being written: stride minus shape times stride.
    assign cfg_desc = dim_desc_t'(cfg_wdata);
    assign lhs_prod = cfg_desc.shape * cfg_desc.lhs_stride;
    assign rhs_prod = cfg_desc.shape * cfg_desc.rhs_stride;
    assign out_prod = cfg_desc.shape * cfg_desc.out_stride;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < DIM_SLOTS; d++) begin
                shape_reg[d]  <= '0;
                stride_reg[d] <= '0;
                wrap_reg[d]   <= '0;
            end
            dims_in_use_reg   <= DIMS_RESET;
            element_count_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index < CFG_INDEX_BITS'(DIM_SLOTS)) begin
                shape_reg[cfg_index[DIM_IDX_BITS-1:0]]      <= cfg_desc.shape;
                stride_reg[cfg_index[DIM_IDX_BITS-1:0]].lhs <= OFFSET_BITS'(cfg_desc.lhs_stride);
                stride_reg[cfg_index[DIM_IDX_BITS-1:0]].rhs <= OFFSET_BITS'(cfg_desc.rhs_stride);
                stride_reg[cfg_index[DIM_IDX_BITS-1:0]].out <= OFFSET_BITS'(cfg_desc.out_stride);
                wrap_reg[cfg_index[DIM_IDX_BITS-1:0]].lhs   <=
                    OFFSET_BITS'(cfg_desc.lhs_stride) - OFFSET_BITS'(lhs_prod);
                wrap_reg[cfg_index[DIM_IDX_BITS-1:0]].rhs   <=
                    OFFSET_BITS'(cfg_desc.rhs_stride) - OFFSET_BITS'(rhs_prod);
                wrap_reg[cfg_index[DIM_IDX_BITS-1:0]].out   <=
                    OFFSET_BITS'(cfg_desc.out_stride) - OFFSET_BITS'(out_prod);
            end else if (cfg_index == REG_DIMS_IN_USE) begin
                dims_in_use_reg <= cfg_wdata[DIMS_BITS-1:0];
            end else if (cfg_index == REG_ELEMENT_COUNT) begin
                element_count_reg <= cfg_wdata[COUNT_BITS-1:0];
            end
        end
    end

    // Number of live dimensions: zero acts as one, large values clamp.
    always_comb begin
        if (dims_in_use_reg == '0) begin
            used_dims = DIMS_BITS'(1);
        end else if (dims_in_use_reg > DIMS_BITS'(DIM_SLOTS)) begin
            used_dims = DIMS_BITS'(DIM_SLOTS);
        end else begin
            used_dims = dims_in_use_reg;
        end
        inner_dim = used_dims - DIMS_BITS'(1);
    end

    // Odometer step: restart clears the walk, then the carry runs outward.
    always_comb begin
        position_cur = s_restart ? '0 : position_reg;
        done_cur     = s_restart ? '0 : elements_done_reg;
        step_overrun = done_cur >= element_count_reg;
        carry        = 1'b0;
        touched      = 1'b0;
        wraps        = 1'b0;
        for (int d = DIM_SLOTS - 1; d >= 0; d--) begin
            counter_cur[d] = s_restart ? '0 : dim_counter_reg[d];
            counter_inc[d] = counter_cur[d] + 1'b1;
            touched = (DIMS_BITS'(d) == inner_dim) || ((DIMS_BITS'(d) < inner_dim) && carry);
            wraps   = counter_inc[d] >= shape_reg[d];
            if (touched) begin
                dim_counter_next[d] = wraps ? '0 : counter_inc[d];
                dim_step[d]         = wraps ? wrap_reg[d] : stride_reg[d];
            end else begin
                dim_counter_next[d] = counter_cur[d];
                dim_step[d]         = '0;
            end
            carry = touched && wraps;
        end

        // Sum the per-dimension contributions into each offset.
        position_next = position_cur;
        for (int d = 0; d < DIM_SLOTS; d++) begin
            position_next.lhs = position_next.lhs + dim_step[d].lhs;
            position_next.rhs = position_next.rhs + dim_step[d].rhs;
            position_next.out = position_next.out + dim_step[d].out;
        end
        elements_done_next = done_cur + 1'b1;
    end

    // Walk state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < DIM_SLOTS; d++) begin
                dim_counter_reg[d] <= '0;
            end
            position_reg      <= '0;
            elements_done_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                m_valid_reg         <= 1'b1;
                m_element_index_reg <= done_cur;
                if (step_overrun) begin
                    // Past the end: only a restart clear takes effect.
                    for (int d = 0; d < DIM_SLOTS; d++) begin
                        dim_counter_reg[d] <= counter_cur[d];
                    end
                    position_reg      <= position_cur;
                    elements_done_reg <= done_cur;
                    m_offsets_reg     <= '0;
                    m_last_reg        <= 1'b0;
                    m_overrun_reg     <= 1'b1;
                end else begin
                    for (int d = 0; d < DIM_SLOTS; d++) begin
                        dim_counter_reg[d] <= dim_counter_next[d];
                    end
                    position_reg      <= position_next;
                    elements_done_reg <= elements_done_next;
                    m_offsets_reg     <= position_cur;
                    m_last_reg        <= elements_done_next == element_count_reg;
                    m_overrun_reg     <= 1'b0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_lhs_addr      = m_offsets_reg.lhs;
    assign m_rhs_addr      = m_offsets_reg.rhs;
    assign m_out_addr      = m_offsets_reg.out;
    assign m_element_index = m_element_index_reg;
    assign m_last          = m_last_reg;
    assign m_overrun       = m_overrun_reg;

    // An overrun result carries no offsets and is never the last element.
    `STOG_ASSERT_IMPLIES(a_overrun_clean, m_valid && m_overrun, m_offsets_reg == '0 && !m_last)
    // A served element without restart moves the element count forward by exactly one.
    `STOG_ASSERT_NEXT(a_done_advances, accept && !s_restart && !step_overrun, elements_done_reg == $past(elements_done_reg) + 1'b1)
    // A request past the end without restart leaves the walk untouched.
    `STOG_ASSERT_NEXT(a_overrun_holds, accept && !s_restart && step_overrun, $stable(position_reg) && $stable(elements_done_reg))
    // A served element reports the count it was taken at.
    `STOG_ASSERT_NEXT(a_index_matches, accept && !step_overrun, m_element_index == $past(done_cur) && !m_overrun)

endmodule
